@@ hw/rtl/ethhp_pkg.sv @@
// Shared types, field codes and protocol constants for the L2/L3/L4 header parser.
`default_nettype none

package ethhp_pkg;

  // Frame length counter width; it holds the largest frame size itself.
  localparam int unsigned FRAME_LEN_W         = 17;
  localparam int unsigned MAX_FRAME_BYTES_DEF = 65536;
  localparam int unsigned ADDR_W              = 64;
  localparam int unsigned PORT_W              = 16;
  // IPv4 transport start, 14 plus the header length field scaled by four, lands in 14..74.
  localparam int unsigned IPV4_TS_W           = 7;
  // An extension header skip of 8 + 8 * length byte fits in 12 bits.
  localparam int unsigned SKIP_W              = 12;

  // Ethernet types.
  localparam logic [15:0] ETYPE_IPV4 = 16'h0800;
  localparam logic [15:0] ETYPE_IPV6 = 16'h86DD;

  // IP protocol and next header codes.
  localparam logic [7:0] PROTO_TCP    = 8'd6;
  localparam logic [7:0] PROTO_UDP    = 8'd17;
  localparam logic [7:0] NH_HOP_OPTS  = 8'd0;
  localparam logic [7:0] NH_ROUTING   = 8'd43;
  localparam logic [7:0] NH_FRAGMENT  = 8'd44;
  localparam logic [7:0] NH_DEST_OPTS = 8'd60;

  // Byte positions within the frame.
  localparam logic [FRAME_LEN_W-1:0] POS_ETYPE_HI   = 17'd12;
  localparam logic [FRAME_LEN_W-1:0] POS_ETYPE_LO   = 17'd13;
  localparam logic [FRAME_LEN_W-1:0] ETH_HDR_LEN    = 17'd14;
  localparam logic [FRAME_LEN_W-1:0] POS_IPV6_NH    = 17'd20;
  localparam logic [FRAME_LEN_W-1:0] POS_IPV6_SRC   = 17'd22;
  localparam logic [FRAME_LEN_W-1:0] POS_IPV4_PROTO = 17'd23;
  localparam logic [FRAME_LEN_W-1:0] POS_IPV4_SRC   = 17'd26;
  localparam logic [FRAME_LEN_W-1:0] POS_IPV4_DST   = 17'd30;
  localparam logic [FRAME_LEN_W-1:0] IPV4_END       = 17'd34;
  localparam logic [FRAME_LEN_W-1:0] IPV6_END       = 17'd54;

  // Header sizes.
  localparam logic [FRAME_LEN_W-1:0] PORT_BYTES    = 17'd4;
  localparam logic [FRAME_LEN_W:0]   TCP_HDR_LEN   = 18'd20;
  localparam logic [FRAME_LEN_W:0]   UDP_HDR_LEN   = 18'd8;
  localparam logic [SKIP_W-1:0]      EXT_UNIT_LEN  = 12'd8;
  localparam logic [SKIP_W-1:0]      FRAG_HDR_LEN  = 12'd8;
  localparam logic [IPV4_TS_W-1:0]   ETH_HDR_LEN_S = 7'd14;

  // Result codes.
  localparam logic [1:0] NET_OTHER      = 2'd0;
  localparam logic [1:0] NET_IPV4       = 2'd1;
  localparam logic [1:0] NET_IPV6       = 2'd2;
  localparam logic [1:0] TRANSPORT_NONE = 2'd0;
  localparam logic [1:0] TRANSPORT_TCP  = 2'd1;
  localparam logic [1:0] TRANSPORT_UDP  = 2'd2;

  typedef struct packed {
    logic [7:0] frame_byte;
    logic       frame_last;
  } in_beat_t;

  typedef struct packed {
    logic [FRAME_LEN_W-1:0] frame_length;
    logic [1:0]             network_layer;
    logic                   addresses_valid;
    logic [1:0]             transport_layer;
    logic                   ports_valid;
    logic [PORT_W-1:0]      source_port;
    logic [PORT_W-1:0]      destination_port;
    logic [ADDR_W-1:0]      source_addr_high;
    logic [ADDR_W-1:0]      source_addr_low;
    logic [ADDR_W-1:0]      dest_addr_high;
    logic [ADDR_W-1:0]      dest_addr_low;
  } out_beat_t;

  // IPv6 extension headers that the parser walks over.
  function automatic logic is_ext_hdr(input logic [7:0] nh);
    return (nh == NH_HOP_OPTS) || (nh == NH_ROUTING) ||
           (nh == NH_FRAGMENT) || (nh == NH_DEST_OPTS);
  endfunction

endpackage

`default_nettype wire

@@ hw/rtl/eth_ip_l4_header_parser_core.sv @@
// Top level of the Ethernet / IPv4 / IPv6 / TCP / UDP header parser.
`default_nettype none

// The parser takes one frame byte per clock beat on the input channel, with a
// last flag on the final byte, and returns one result beat per frame: the
// saturated frame length, the network layer chosen by the Ethernet type, the
// IP addresses once the IP header is complete, and TCP or UDP ports once that
// header fits in the frame. IPv4 options are skipped by IHL and IPv6
// extension headers 0, 43, 44 and 60 are walked from the end of the fixed
// IPv6 header. A new byte is accepted on every clock unless a frame's last
// byte must wait for the snapshot register to be freed; the per-byte field
// capture is a single pass of comparators against the byte counter. For the
// result beat of a frame, the last byte is first folded into the frame state
// and snapshotted, then the length checks are evaluated from the snapshot into
// the output register. Bytes past MAX_FRAME_BYTES are accepted and ignored.
module eth_ip_l4_header_parser_core
  import ethhp_pkg::*;
#(
  parameter int unsigned MAX_FRAME_BYTES = MAX_FRAME_BYTES_DEF
) (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      in_valid_i,
  output logic           in_ready_o,
  input  wire in_beat_t  in_data_i,
  output logic           out_valid_o,
  input  wire logic      out_ready_i,
  output out_beat_t      out_data_o
);

  // Input register.
  logic     s0_valid_q;
  in_beat_t s0_beat_q;

  // Frame state.
  logic [FRAME_LEN_W-1:0] off_q, off_d;
  logic [15:0]            etype_q, etype_d;
  logic [IPV4_TS_W-1:0]   ts_q, ts_d;
  logic [7:0]             nh_q, nh_d;
  logic [FRAME_LEN_W-1:0] ext_q, ext_d;
  logic [7:0]             pend_q, pend_d;
  logic [ADDR_W-1:0]      addr_q [4];
  logic [ADDR_W-1:0]      addr_d [4];
  logic [PORT_W-1:0]      port_q [2];
  logic [PORT_W-1:0]      port_d [2];

  // Snapshot of the frame state taken on the last byte.
  logic                   snap_valid_q;
  logic [FRAME_LEN_W-1:0] snap_len_q;
  logic [15:0]            snap_etype_q;
  logic [IPV4_TS_W-1:0]   snap_ts_q;
  logic [7:0]             snap_nh_q;
  logic [FRAME_LEN_W-1:0] snap_ext_q;
  logic [ADDR_W-1:0]      snap_addr_q [4];
  logic [PORT_W-1:0]      snap_port_q [2];

  // Output register.
  logic      out_valid_q;
  out_beat_t out_beat_q;
  out_beat_t fin;

  // Pipeline flow control.
  logic out_load, snap_free, proc, frame_end;

  assign out_load   = !out_valid_q || out_ready_i;
  assign snap_free  = !snap_valid_q || out_load;
  assign proc       = s0_valid_q && (!s0_beat_q.frame_last || snap_free);
  assign frame_end  = proc && s0_beat_q.frame_last;
  assign in_ready_o = !s0_valid_q || proc;

  // Per-byte field capture.
  logic [FRAME_LEN_W-1:0] pos;
  logic [7:0]             data_byte;
  logic [IPV4_TS_W-1:0]   ts_cur;
  logic [FRAME_LEN_W-1:0] ts_cur_w, v4_rel, v6_rel, v6_addr_rel;
  logic [SKIP_W-1:0]      skip;

  always_comb begin
    pos         = off_q;
    data_byte   = s0_beat_q.frame_byte;
    ts_cur      = (pos == ETH_HDR_LEN) ?
                  (ETH_HDR_LEN_S + {1'b0, data_byte[3:0], 2'b00}) : ts_q;
    ts_cur_w    = FRAME_LEN_W'(ts_cur);
    v4_rel      = pos - ts_cur_w;
    v6_rel      = pos - ext_q;
    v6_addr_rel = pos - POS_IPV6_SRC;
    skip        = (nh_q == NH_FRAGMENT) ? FRAG_HDR_LEN :
                  (EXT_UNIT_LEN + {1'b0, data_byte, 3'b000});

    off_d   = off_q;
    etype_d = etype_q;
    ts_d    = ts_q;
    nh_d    = nh_q;
    ext_d   = ext_q;
    pend_d  = pend_q;
    addr_d  = addr_q;
    port_d  = port_q;

    if (off_q < FRAME_LEN_W'(MAX_FRAME_BYTES)) begin
      off_d = off_q + 1'b1;
      if (pos == POS_ETYPE_HI || pos == POS_ETYPE_LO) begin
        etype_d = {etype_q[7:0], data_byte};
      end else if (pos >= ETH_HDR_LEN) begin
        if (etype_q == ETYPE_IPV4) begin
          ts_d = ts_cur;
          if (pos == POS_IPV4_PROTO) begin
            nh_d = data_byte;
          end
          if (pos >= POS_IPV4_SRC && pos < POS_IPV4_DST) begin
            addr_d[1] = {addr_q[1][ADDR_W-9:0], data_byte};
          end
          if (pos >= POS_IPV4_DST && pos < IPV4_END) begin
            addr_d[3] = {addr_q[3][ADDR_W-9:0], data_byte};
          end
          if (pos >= ts_cur_w && v4_rel < PORT_BYTES) begin
            port_d[v4_rel[1]] = {port_q[v4_rel[1]][PORT_W-9:0], data_byte};
          end
        end else if (etype_q == ETYPE_IPV6) begin
          if (pos == POS_IPV6_NH) begin
            nh_d = data_byte;
          end
          if (pos >= POS_IPV6_SRC && pos < IPV6_END) begin
            addr_d[v6_addr_rel[4:3]] = {addr_q[v6_addr_rel[4:3]][ADDR_W-9:0], data_byte};
          end
          if (pos >= IPV6_END) begin
            if (is_ext_hdr(nh_q)) begin
              // Walk one extension header: next header byte, then length byte.
              if (pos == ext_q) begin
                pend_d = data_byte;
              end else if (pos == ext_q + 1'b1) begin
                ext_d = ext_q + FRAME_LEN_W'(skip);
                nh_d  = pend_q;
              end
            end else if (pos >= ext_q && v6_rel < PORT_BYTES) begin
              port_d[v6_rel[1]] = {port_q[v6_rel[1]][PORT_W-9:0], data_byte};
            end
          end
        end
      end
    end
  end

  // End-of-frame evaluation from the snapshot.
  logic                   trans_ok;
  logic [FRAME_LEN_W-1:0] trans_start;
  logic [7:0]             proto;
  logic [FRAME_LEN_W:0]   need;

  always_comb begin
    fin         = '0;
    trans_ok    = 1'b0;
    trans_start = '0;
    proto       = '0;
    need        = UDP_HDR_LEN;
    fin.frame_length = snap_len_q;

    if (snap_len_q >= ETH_HDR_LEN && snap_etype_q == ETYPE_IPV4) begin
      fin.network_layer = NET_IPV4;
      if (snap_len_q >= IPV4_END) begin
        fin.addresses_valid = 1'b1;
        fin.source_addr_low = {32'd0, snap_addr_q[1][31:0]};
        fin.dest_addr_low   = {32'd0, snap_addr_q[3][31:0]};
        trans_ok    = 1'b1;
        trans_start = FRAME_LEN_W'(snap_ts_q);
        proto       = snap_nh_q;
      end
    end else if (snap_len_q >= ETH_HDR_LEN && snap_etype_q == ETYPE_IPV6) begin
      fin.network_layer = NET_IPV6;
      if (snap_len_q >= IPV6_END) begin
        fin.addresses_valid  = 1'b1;
        fin.source_addr_high = snap_addr_q[0];
        fin.source_addr_low  = snap_addr_q[1];
        fin.dest_addr_high   = snap_addr_q[2];
        fin.dest_addr_low    = snap_addr_q[3];
        if (!is_ext_hdr(snap_nh_q) && snap_ext_q <= snap_len_q) begin
          trans_ok    = 1'b1;
          trans_start = snap_ext_q;
          proto       = snap_nh_q;
        end
      end
    end

    if (trans_ok && (proto == PROTO_TCP || proto == PROTO_UDP)) begin
      need                = (proto == PROTO_TCP) ? TCP_HDR_LEN : UDP_HDR_LEN;
      fin.transport_layer = (proto == PROTO_TCP) ? TRANSPORT_TCP : TRANSPORT_UDP;
      if ({1'b0, trans_start} + need <= {1'b0, snap_len_q}) begin
        fin.ports_valid      = 1'b1;
        fin.source_port      = snap_port_q[0];
        fin.destination_port = snap_port_q[1];
      end
    end
  end

  // Input register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s0_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      s0_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      s0_beat_q <= in_data_i;
    end
  end

  // Frame state; cleared after the last byte of each frame.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      off_q   <= '0;
      etype_q <= '0;
      ts_q    <= '0;
      nh_q    <= '0;
      ext_q   <= IPV6_END;
      pend_q  <= '0;
      addr_q  <= '{default: '0};
      port_q  <= '{default: '0};
    end else if (frame_end) begin
      off_q   <= '0;
      etype_q <= '0;
      ts_q    <= '0;
      nh_q    <= '0;
      ext_q   <= IPV6_END;
      pend_q  <= '0;
      addr_q  <= '{default: '0};
      port_q  <= '{default: '0};
    end else if (proc) begin
      off_q   <= off_d;
      etype_q <= etype_d;
      ts_q    <= ts_d;
      nh_q    <= nh_d;
      ext_q   <= ext_d;
      pend_q  <= pend_d;
      addr_q  <= addr_d;
      port_q  <= port_d;
    end
  end

  // Snapshot stage.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      snap_valid_q <= 1'b0;
    end else if (snap_free) begin
      snap_valid_q <= frame_end;
    end
  end

  always_ff @(posedge clk_i) begin
    if (frame_end) begin
      snap_len_q   <= off_d;
      snap_etype_q <= etype_d;
      snap_ts_q    <= ts_d;
      snap_nh_q    <= nh_d;
      snap_ext_q   <= ext_d;
      snap_addr_q  <= addr_d;
      snap_port_q  <= port_d;
    end
  end

  // Output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= snap_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load && snap_valid_q) begin
      out_beat_q <= fin;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_beat_q;

endmodule

`default_nettype wire
